// ----- rtl/isl_pkg.sv -----
`timescale 1ns / 1ps

package isl_pkg;

    // List geometry
    localparam int DEPTH   = 16;
    localparam int WIDTH   = 32;

    // Fixed port field widths
    localparam int REQ_W   = 3;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Derived widths
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_POP    = 3'd3,
        REQ_READ   = 3'd4,
        REQ_WRITE  = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_INDEX = 2'd3
    } t_status;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_PUT    = 2'd3
    } t_act;

    // Command broadcast along the chain
    typedef struct packed {
        t_act             act;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] held;
        logic [WIDTH-1:0] val;
    } t_cell_cmd;

endpackage

// ----- rtl/isl_cell.sv -----
`timescale 1ns / 1ps

module isl_cell (
    input  logic                      i_clk,
    input  isl_pkg::t_cell_cmd        i_cmd,
    input  logic [isl_pkg::IDX_W-1:0] i_index,
    input  logic [isl_pkg::WIDTH-1:0] i_left,
    input  logic [isl_pkg::WIDTH-1:0] i_right,
    output logic [isl_pkg::WIDTH-1:0] o_data
);
    import isl_pkg::*;

    logic [WIDTH-1:0] r_entry;
    logic [WIDTH-1:0] n_entry;
    logic [CMP_W-1:0] w_idx;

    assign w_idx  = CMP_W'(i_index);
    assign o_data = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.act)
            ACT_INSERT: begin
                // take the new value at the slot, shift later entries up
                if (w_idx == i_cmd.pos) begin
                    n_entry = i_cmd.val;
                end else if (w_idx > i_cmd.pos && w_idx <= i_cmd.held) begin
                    n_entry = i_left;
                end
            end
            ACT_REMOVE: begin
                // close the gap: pull from the right neighbor
                if (w_idx >= i_cmd.pos && (w_idx + CMP_W'(1)) < i_cmd.held) begin
                    n_entry = i_right;
                end
            end
            ACT_PUT: begin
                if (w_idx == i_cmd.pos) begin
                    n_entry = i_cmd.val;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/indexed_shift_list.sv -----
`timescale 1ns / 1ps

// Ordered list of DEPTH entries kept in a chain of cells, one entry per cell.
// Input channel (i_in_valid / o_in_stall) carries one request: append,
// insert at i_position, remove at i_position, pop, read or write. The
// output channel (o_out_valid / i_out_stall) returns exactly one result per
// request: the data taken out, a status (ok, full, empty, bad index), the
// entry count after the request and the empty / full flags.
// A result is registered and appears in the cycle after its request is
// accepted; all cells shift in parallel on the same edge. Throughput:
// one request per cycle while the receiver keeps up.
// The single output register decouples the sides: a new request is taken
// whenever that register is empty or its result is being taken in the same
// cycle. While the receiver stalls with a result pending, o_in_stall is high
// and the pending result holds steady.
// A failing request (full, empty, bad index) changes nothing and returns
// zero data. Unused request codes return ok with zero data.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared since only entries below the count
// are ever read.

module indexed_shift_list (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [isl_pkg::REQ_W-1:0]   i_req_type,
    input  logic [isl_pkg::POS_W-1:0]   i_position,
    input  logic [isl_pkg::VAL_W-1:0]   i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [isl_pkg::DATA_W-1:0]  o_data_out,
    output logic [isl_pkg::STAT_W-1:0]  o_status,
    output logic [isl_pkg::COUNT_W-1:0] o_entry_count,
    output logic                        o_is_empty,
    output logic                        o_is_full
);
    import isl_pkg::*;

    // list count
    logic [CNT_W-1:0]   r_held;
    logic [CNT_W-1:0]   n_held;

    // result register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_data;
    logic [STAT_W-1:0]  r_status;
    logic [COUNT_W-1:0] r_count;
    logic               r_empty;
    logic               r_full;

    logic               w_accept;
    t_cell_cmd          w_cmd;
    t_act               w_act;
    t_status            w_status;
    logic [DATA_W-1:0]  w_data;
    logic [IDX_W-1:0]   w_rd_idx;
    logic [WIDTH-1:0]   w_rd_data;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_held;
    logic [CMP_W-1:0]   w_cmd_pos;
    logic               w_is_full;
    logic               w_is_empty;
    logic [WIDTH-1:0]   w_entry [DEPTH];

    // Accept whenever the result slot is free or drains this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_pos      = CMP_W'(i_position);
    assign w_held     = CMP_W'(r_held);
    assign w_is_full  = (r_held == CNT_W'(DEPTH));
    assign w_is_empty = (r_held == '0);

    // One read port into the chain: pop reads the tail, the rest read at the index
    assign w_rd_data  = w_entry[w_rd_idx];

    // Decode the request and check it against the current count
    always_comb begin
        w_act     = ACT_HOLD;
        w_status  = ST_OK;
        w_data    = '0;
        w_cmd_pos = w_pos;
        w_rd_idx  = IDX_W'(i_position);
        n_held    = r_held;
        case (t_req'(i_req_type))
            REQ_APPEND: begin
                if (w_is_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_act     = ACT_PUT;
                    w_cmd_pos = w_held;
                    n_held    = r_held + CNT_W'(1);
                end
            end
            REQ_INSERT: begin
                if (w_is_full) begin
                    w_status = ST_FULL;
                end else if (w_pos > w_held) begin
                    w_status = ST_INDEX;
                end else begin
                    w_act  = ACT_INSERT;
                    n_held = r_held + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_held) begin
                    w_status = ST_INDEX;
                end else begin
                    w_act  = ACT_REMOVE;
                    w_data = DATA_W'(w_rd_data);
                    n_held = r_held - CNT_W'(1);
                end
            end
            REQ_POP: begin
                // the tail simply falls out of the count; cells keep their data
                w_rd_idx = IDX_W'(r_held - CNT_W'(1));
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_data = DATA_W'(w_rd_data);
                    n_held = r_held - CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_held) begin
                    w_status = ST_INDEX;
                end else begin
                    w_data = DATA_W'(w_rd_data);
                end
            end
            REQ_WRITE: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_held) begin
                    w_status = ST_INDEX;
                end else begin
                    w_act = ACT_PUT;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Broadcast the command; cells act only on an accepted request
    always_comb begin
        w_cmd.act  = w_accept ? w_act : ACT_HOLD;
        w_cmd.pos  = w_cmd_pos;
        w_cmd.held = w_held;
        w_cmd.val  = WIDTH'(i_value);
    end

    // Chain of cells; each sees both neighbors, the ends see zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_left;
        logic [WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_entry[g])
        );
    end

    // Count register and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= w_data;
            r_status <= w_status;
            r_count  <= COUNT_W'(n_held);
            r_empty  <= (n_held == '0);
            r_full   <= (n_held == CNT_W'(DEPTH));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_data;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

endmodule

// ----- rtl/isl_check.sv -----
`timescale 1ns / 1ps

module isl_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [isl_pkg::DATA_W-1:0]  o_data_out,
    input  logic [isl_pkg::STAT_W-1:0]  o_status,
    input  logic [isl_pkg::COUNT_W-1:0] o_entry_count,
    input  logic                        o_is_empty,
    input  logic                        o_is_full
);
    import isl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_out)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result changed");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    // a failed request returns no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_data_out == '0))
        else $error("failed request returned data");

    // full status only on a full list, empty status only on an empty one
    a_full_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_is_full && !o_is_empty)
        else $error("full status without full list");

    a_empty_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_is_empty && !o_is_full)
        else $error("empty status without empty list");

endmodule

bind indexed_shift_list isl_check u_isl_check (.*);
